@@ rtl/idiv_pkg.sv @@
// Shared types and constants for the 128-bit divider.
package idiv_pkg;

   localparam int LIMB_W    = 64;
   localparam int WORD_W    = 2 * LIMB_W;
   localparam int DIV_STEPS = WORD_W;

   // One word in flight through the division chain.
   typedef struct packed {
      logic              aneg;   // dividend was negative (signed mode)
      logic              bneg;   // divisor was negative (signed mode)
      logic              dz;     // divisor is zero
      logic [WORD_W-1:0] rem;    // partial remainder
      logic [WORD_W-1:0] nq;     // dividend bits out the top, quotient bits in the bottom
      logic [WORD_W-1:0] d;      // divisor magnitude
   } stage_type;

endpackage

@@ rtl/int128_divider.sv @@
// Top level: pipelined 128-bit signed/unsigned divider, one bit cell per quotient bit.
//
//   channel | dir | handshake          | word
//   req     | in  | req_valid/req_stall | signed_mode, dividend_lo/hi, divisor_lo/hi
//   rsp     | out | rsp_valid/rsp_stall | quotient_lo/hi, remainder_lo/hi, divide_by_zero
//
// One word in per cycle while req_stall is low; each request passes through these stages in order:
// one operand stage, 128 division cells (one 129-bit trial subtract each), one output stage.
// Reset clears only the valid bits of the stages.
// The whole pipeline advances together; it freezes while a result sits in the
// output register under rsp_stall, and req_stall is raised for that time.
module int128_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_signed_mode,
   input  logic [63:0] req_dividend_lo,
   input  logic [63:0] req_dividend_hi,
   input  logic [63:0] req_divisor_lo,
   input  logic [63:0] req_divisor_hi,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_quotient_lo,
   output logic [63:0] rsp_quotient_hi,
   output logic [63:0] rsp_remainder_lo,
   output logic [63:0] rsp_remainder_hi,
   output logic        rsp_divide_by_zero
);

   logic                en;
   logic                chain_valid [0:idiv_pkg::DIV_STEPS];
   idiv_pkg::stage_type chain_stage [0:idiv_pkg::DIV_STEPS];

   assign en        = ~(rsp_valid & rsp_stall);
   assign req_stall = ~en;

   idiv_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid),
      .signed_mode (req_signed_mode),
      .dividend_lo (req_dividend_lo),
      .dividend_hi (req_dividend_hi),
      .divisor_lo  (req_divisor_lo),
      .divisor_hi  (req_divisor_hi),
      .out_valid   (chain_valid[0]),
      .out_stage   (chain_stage[0])
   );

   for (genvar i = 0; i < idiv_pkg::DIV_STEPS; i++) begin : g_cell
      idiv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_valid[i]),
         .in_stage  (chain_stage[i]),
         .out_valid (chain_valid[i+1]),
         .out_stage (chain_stage[i+1])
      );
   end

   idiv_fix u_fix (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_valid       (chain_valid[idiv_pkg::DIV_STEPS]),
      .in_stage       (chain_stage[idiv_pkg::DIV_STEPS]),
      .out_valid      (rsp_valid),
      .quotient_lo    (rsp_quotient_lo),
      .quotient_hi    (rsp_quotient_hi),
      .remainder_lo   (rsp_remainder_lo),
      .remainder_hi   (rsp_remainder_hi),
      .divide_by_zero (rsp_divide_by_zero)
   );

endmodule

@@ rtl/idiv_prep.sv @@
// Operand stage: sign detection, magnitudes and zero-divisor check.
module idiv_prep (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic                        signed_mode,
   input  logic [idiv_pkg::LIMB_W-1:0] dividend_lo,
   input  logic [idiv_pkg::LIMB_W-1:0] dividend_hi,
   input  logic [idiv_pkg::LIMB_W-1:0] divisor_lo,
   input  logic [idiv_pkg::LIMB_W-1:0] divisor_hi,
   output logic                        out_valid,
   output idiv_pkg::stage_type         out_stage
);

   logic [idiv_pkg::WORD_W-1:0] a;
   logic [idiv_pkg::WORD_W-1:0] b;
   logic                        aneg;
   logic                        bneg;
   logic                        valid_ff;
   idiv_pkg::stage_type         stage_ff;
   idiv_pkg::stage_type         stage_in;

   always_comb begin
      a    = {dividend_hi, dividend_lo};
      b    = {divisor_hi, divisor_lo};
      aneg = signed_mode & a[idiv_pkg::WORD_W-1];
      bneg = signed_mode & b[idiv_pkg::WORD_W-1];
      stage_in.aneg = aneg;
      stage_in.bneg = bneg;
      stage_in.dz   = (b == '0);
      stage_in.rem  = '0;
      // two's complement negate covers the most negative value
      stage_in.nq   = aneg ? (~a + idiv_pkg::WORD_W'(1)) : a;
      stage_in.d    = bneg ? (~b + idiv_pkg::WORD_W'(1)) : b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

@@ rtl/idiv_cell.sv @@
// One restoring-division step: shift in a dividend bit, trial subtract, keep or restore.
module idiv_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  idiv_pkg::stage_type in_stage,
   output logic                out_valid,
   output idiv_pkg::stage_type out_stage
);

   logic [idiv_pkg::WORD_W:0]   trial;
   logic [idiv_pkg::WORD_W+1:0] diff;
   logic                        ge;
   logic                        valid_ff;
   idiv_pkg::stage_type         stage_ff;
   idiv_pkg::stage_type         stage_in;

   always_comb begin
      // 129-bit trial value; its top bit is the carry out of the shift
      trial = {in_stage.rem, in_stage.nq[idiv_pkg::WORD_W-1]};
      diff  = {1'b0, trial} - {2'b00, in_stage.d};
      ge    = ~diff[idiv_pkg::WORD_W+1];
      stage_in      = in_stage;
      stage_in.rem  = ge ? diff[idiv_pkg::WORD_W-1:0] : trial[idiv_pkg::WORD_W-1:0];
      stage_in.nq   = {in_stage.nq[idiv_pkg::WORD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

@@ rtl/idiv_fix.sv @@
// Result stage: sign correction, zero-divisor override and output register.
module idiv_fix (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  idiv_pkg::stage_type         in_stage,
   output logic                        out_valid,
   output logic [idiv_pkg::LIMB_W-1:0] quotient_lo,
   output logic [idiv_pkg::LIMB_W-1:0] quotient_hi,
   output logic [idiv_pkg::LIMB_W-1:0] remainder_lo,
   output logic [idiv_pkg::LIMB_W-1:0] remainder_hi,
   output logic                        divide_by_zero
);

   logic [idiv_pkg::WORD_W-1:0] q_in;
   logic [idiv_pkg::WORD_W-1:0] r_in;
   logic [idiv_pkg::WORD_W-1:0] q_ff;
   logic [idiv_pkg::WORD_W-1:0] r_ff;
   logic                        dz_ff;
   logic                        valid_ff;

   always_comb begin
      q_in = (in_stage.aneg ^ in_stage.bneg) ? (~in_stage.nq + idiv_pkg::WORD_W'(1))
                                             : in_stage.nq;
      r_in = in_stage.aneg ? (~in_stage.rem + idiv_pkg::WORD_W'(1)) : in_stage.rem;
      if (in_stage.dz) begin
         q_in = '0;
         r_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff  <= q_in;
         r_ff  <= r_in;
         dz_ff <= in_stage.dz;
      end
   end

   assign out_valid      = valid_ff;
   assign quotient_lo    = q_ff[idiv_pkg::LIMB_W-1:0];
   assign quotient_hi    = q_ff[idiv_pkg::WORD_W-1:idiv_pkg::LIMB_W];
   assign remainder_lo   = r_ff[idiv_pkg::LIMB_W-1:0];
   assign remainder_hi   = r_ff[idiv_pkg::WORD_W-1:idiv_pkg::LIMB_W];
   assign divide_by_zero = dz_ff;

endmodule

@@ tb/tb_int128_divider.sv @@
// Self-checking testbench for the pipelined 128-bit signed/unsigned divider.
`timescale 1ns / 100ps

module tb_int128_divider;

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 160;
   localparam int          RANDOM_OPS   = 1200;
   localparam logic [127:0] MOST_NEG    = {1'b1, 127'b0};
   localparam logic [127:0] ALL_ONES    = '1;

   typedef struct packed {
      logic                        signed_mode;
      logic [idiv_pkg::LIMB_W-1:0] dividend_lo;
      logic [idiv_pkg::LIMB_W-1:0] dividend_hi;
      logic [idiv_pkg::LIMB_W-1:0] divisor_lo;
      logic [idiv_pkg::LIMB_W-1:0] divisor_hi;
   } div_op_type;

   typedef struct packed {
      logic [idiv_pkg::LIMB_W-1:0] quotient_lo;
      logic [idiv_pkg::LIMB_W-1:0] quotient_hi;
      logic [idiv_pkg::LIMB_W-1:0] remainder_lo;
      logic [idiv_pkg::LIMB_W-1:0] remainder_hi;
      logic                        divide_by_zero;
   } quot_rem_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY
   } stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_signed_mode = 1'b0;
   logic [63:0] req_dividend_lo = '0;
   logic [63:0] req_dividend_hi = '0;
   logic [63:0] req_divisor_lo = '0;
   logic [63:0] req_divisor_hi = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_quotient_lo;
   logic [63:0] rsp_quotient_hi;
   logic [63:0] rsp_remainder_lo;
   logic [63:0] rsp_remainder_hi;
   logic        rsp_divide_by_zero;

   div_op_type   pending_ops[$];
   quot_rem_type quot_rem_due[$];
   int           failures = 0;
   int           clock_cycles = 0;

   int128_divider dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_signed_mode    (req_signed_mode),
      .req_dividend_lo    (req_dividend_lo),
      .req_dividend_hi    (req_dividend_hi),
      .req_divisor_lo     (req_divisor_lo),
      .req_divisor_hi     (req_divisor_hi),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient_lo    (rsp_quotient_lo),
      .rsp_quotient_hi    (rsp_quotient_hi),
      .rsp_remainder_lo   (rsp_remainder_lo),
      .rsp_remainder_hi   (rsp_remainder_hi),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always #4 clock = ~clock;

   // Truncating division on magnitudes; quotient sign from both operands,
   // remainder sign from the dividend.
   function automatic quot_rem_type divide_words(div_op_type op);
      logic [idiv_pkg::WORD_W-1:0] num, den, quo, rem;
      logic                        num_neg, den_neg;
      quot_rem_type                res;
      res = '0;
      num = {op.dividend_hi, op.dividend_lo};
      den = {op.divisor_hi, op.divisor_lo};
      if (den == '0) begin
         res.divide_by_zero = 1'b1;
         return res;
      end
      num_neg = op.signed_mode & num[idiv_pkg::WORD_W-1];
      den_neg = op.signed_mode & den[idiv_pkg::WORD_W-1];
      if (num_neg) num = -num;
      if (den_neg) den = -den;
      quo = num / den;
      rem = num % den;
      if (num_neg != den_neg) quo = -quo;
      if (num_neg) rem = -rem;
      res.quotient_lo  = quo[idiv_pkg::LIMB_W-1:0];
      res.quotient_hi  = quo[idiv_pkg::WORD_W-1:idiv_pkg::LIMB_W];
      res.remainder_lo = rem[idiv_pkg::LIMB_W-1:0];
      res.remainder_hi = rem[idiv_pkg::WORD_W-1:idiv_pkg::LIMB_W];
      return res;
   endfunction

   function automatic logic [127:0] rand_word();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   task automatic queue_op(input logic sgn, input logic [127:0] num, input logic [127:0] den);
      div_op_type op;
      op.signed_mode = sgn;
      op.dividend_lo = num[63:0];
      op.dividend_hi = num[127:64];
      op.divisor_lo  = den[63:0];
      op.divisor_hi  = den[127:64];
      pending_ops.push_back(op);
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         failures++;
         if (failures <= 10)
            $display("mismatch %s: expected %h actual %h", name, want, got);
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      div_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            quot_rem_due.push_back(divide_words({req_signed_mode, req_dividend_lo,
                                                  req_dividend_hi, req_divisor_lo,
                                                  req_divisor_hi}));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
               op = pending_ops.pop_front();
               req_signed_mode <= op.signed_mode;
               req_dividend_lo <= op.dividend_lo;
               req_dividend_hi <= op.dividend_hi;
               req_divisor_lo  <= op.divisor_lo;
               req_divisor_hi  <= op.divisor_hi;
               req_valid       <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern changes every so often; one long hold-off early on
   // so the pipeline fills and pushes back on the request side.
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             rx_cycles = 0;
   int             hold_left = 0;
   bit             hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rx_cycles++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && rx_cycles >= 600) begin
            hold_done = 1'b1;
            hold_left = 399;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 25);
               STALL_PERIODIC: rsp_stall <= (rx_cycles % 3 == 0);
               default:        rsp_stall <= ($urandom_range(0, 99) < 80);
            endcase
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      quot_rem_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (quot_rem_due.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result word: quotient %h%h remainder %h%h",
                        rsp_quotient_hi, rsp_quotient_lo, rsp_remainder_hi, rsp_remainder_lo);
         end else begin
            want = quot_rem_due.pop_front();
            check_field("quotient_lo", want.quotient_lo, rsp_quotient_lo);
            check_field("quotient_hi", want.quotient_hi, rsp_quotient_hi);
            check_field("remainder_lo", want.remainder_lo, rsp_remainder_lo);
            check_field("remainder_hi", want.remainder_hi, rsp_remainder_hi);
            check_field("divide_by_zero", 64'(want.divide_by_zero), 64'(rsp_divide_by_zero));
         end
      end
   end

   initial begin
      while (clock_cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         clock_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [127:0] num, den;
      logic         sgn;
      int           pick;

      // unsigned corners
      queue_op(1'b0, 128'd0, 128'd1);
      queue_op(1'b0, ALL_ONES, 128'd1);
      queue_op(1'b0, ALL_ONES, ALL_ONES);
      queue_op(1'b0, 128'd100, 128'd7);
      queue_op(1'b0, ALL_ONES, MOST_NEG);
      queue_op(1'b0, 128'd5, ALL_ONES);
      queue_op(1'b0, rand_word(), 128'd0);
      queue_op(1'b0, 128'd0, 128'd0);
      queue_op(1'b0, ALL_ONES, {64'd0, 64'hffff_ffff_ffff_fffd});
      queue_op(1'b0, ALL_ONES, {64'h1, 64'd0});
      // signed corners, including the most negative dividend by minus one
      queue_op(1'b1, -128'd7, 128'd2);
      queue_op(1'b1, 128'd7, -128'd2);
      queue_op(1'b1, -128'd7, -128'd2);
      queue_op(1'b1, MOST_NEG, ALL_ONES);
      queue_op(1'b1, MOST_NEG, 128'd1);
      queue_op(1'b1, MOST_NEG, MOST_NEG);
      queue_op(1'b1, ALL_ONES, MOST_NEG);
      queue_op(1'b1, ~MOST_NEG, MOST_NEG);
      queue_op(1'b1, ~MOST_NEG, ALL_ONES);
      queue_op(1'b1, MOST_NEG, 128'd0);
      queue_op(1'b1, 128'd5, -128'd1);
      queue_op(1'b1, -128'd3, 128'd10);
      queue_op(1'b1, rand_word(), {$urandom, $urandom, 64'd0});

      for (int i = 0; i < RANDOM_OPS; i++) begin
         pick = $urandom_range(0, 99);
         sgn  = 1'($urandom_range(0, 1));
         if (pick < 10) begin
            num = rand_word();
            den = rand_word();
         end else begin
            num = rand_word() >> $urandom_range(0, 127);
            den = rand_word() >> $urandom_range(0, 127);
            if (sgn && $urandom_range(0, 1)) num = -num;
            if (sgn && $urandom_range(0, 1)) den = -den;
         end
         if (pick >= 95) begin
            case ($urandom_range(0, 2))
               0:       num = MOST_NEG;
               1:       num = ALL_ONES;
               default: num = '0;
            endcase
            case ($urandom_range(0, 2))
               0:       den = ALL_ONES;
               1:       den = 128'd1;
               default: den = MOST_NEG;
            endcase
         end else if (pick >= 93) begin
            den = '0;
         end
         queue_op(sgn, num, den);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_valid || quot_rem_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ int128_divider.f @@
rtl/idiv_pkg.sv
rtl/idiv_prep.sv
rtl/idiv_cell.sv
rtl/idiv_fix.sv
rtl/int128_divider.sv
tb/tb_int128_divider.sv
